// ----- rtl/core/newton_cotes_sample_integrator_unit_macros.svh -----
// Assertion macros shared by the integrator RTL.
// Expects i_clk and i_rst_n in the scope of each use; no other dependencies.
`ifndef NEWTON_COTES_SAMPLE_INTEGRATOR_UNIT_MACROS_SVH
`define NEWTON_COTES_SAMPLE_INTEGRATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define NCSI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ncsi: assertion failed");
`define NCSI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ncsi: assertion failed");
`else
`define NCSI_ASSERT_IMP(lbl, ante, cons)
`define NCSI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/ncsi_pkg.sv -----
// Shared types and constants of the Newton-Cotes sample integrator.
// No dependencies.
package ncsi_pkg;

    localparam int NI_W        = 13;
    localparam int SCALE_W     = 32;
    localparam int SUM_W       = 52;
    localparam int LO_W        = 32;
    localparam int HI_W        = SUM_W - LO_W;
    localparam int PROD_LO_W   = LO_W + SCALE_W;
    localparam int PROD_HI_W   = HI_W + SCALE_W;
    localparam int MID_W       = PROD_HI_W + 1;
    localparam int RND_W       = 17;
    localparam int RESULT_W    = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int WEIGHT_W    = 6;

    localparam logic [1:0] RULE_TRAP    = 2'd0;
    localparam logic [1:0] RULE_SIMPSON = 2'd1;
    localparam logic [1:0] RULE_BOOLE   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RULE          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_INTERVALS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SCALE    = 2'd2;

    localparam logic [NI_W-1:0]    NUM_INTERVALS_RESET = 13'd4;
    localparam logic [SCALE_W-1:0] STEP_SCALE_RESET    = 32'h0001_0000;

    localparam logic [WEIGHT_W-1:0] W_ZERO       = 6'd0;
    localparam logic [WEIGHT_W-1:0] W_ONE        = 6'd1;
    localparam logic [WEIGHT_W-1:0] W_TWO        = 6'd2;
    localparam logic [WEIGHT_W-1:0] W_FOUR       = 6'd4;
    localparam logic [WEIGHT_W-1:0] W_SEVEN      = 6'd7;
    localparam logic [WEIGHT_W-1:0] W_TWELVE     = 6'd12;
    localparam logic [WEIGHT_W-1:0] W_FOURTEEN   = 6'd14;
    localparam logic [WEIGHT_W-1:0] W_THIRTYTWO  = 6'd32;

    localparam logic [RESULT_W-1:0] RESULT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [RESULT_W-1:0] RESULT_MIN = 64'h8000_0000_0000_0000;
    localparam logic [LO_W:0]       RND_HALF   = 33'h0_0000_8000;

    typedef struct packed {
        logic [1:0]         rule;
        logic [NI_W-1:0]    num_intervals;
        logic [SCALE_W-1:0] step_scale;
    } t_cfg;

endpackage

// ----- rtl/core/ncsi_cfg.sv -----
// Configuration register file: rule, interval count and step scale.
// Depends on ncsi_pkg.
module ncsi_cfg
    import ncsi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RULE:          n_cfg.rule          = i_cfg_data[1:0];
                CFG_NUM_INTERVALS: n_cfg.num_intervals = i_cfg_data[NI_W-1:0];
                CFG_STEP_SCALE:    n_cfg.step_scale    = i_cfg_data[SCALE_W-1:0];
                default:           n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rule          <= RULE_TRAP;
            r_cfg.num_intervals <= NUM_INTERVALS_RESET;
            r_cfg.step_scale    <= STEP_SCALE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ----- rtl/core/ncsi_accum.sv -----
// Weight selection and running weighted sum; hands the final sum to the scaler.
// Depends on ncsi_pkg and the assertion macro header.
`include "newton_cotes_sample_integrator_unit_macros.svh"
module ncsi_accum
    import ncsi_pkg::*;
#(
    parameter int MAX_INTERVALS = 4096,
    parameter int SAMPLE_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_sum_valid,
    input  logic                           i_sum_ready,
    output logic [SUM_W-1:0]               o_sum
);

    localparam int IDX_W = $clog2(MAX_INTERVALS + 1);
    localparam int CMP_W = (IDX_W > NI_W) ? IDX_W : NI_W;

    logic [IDX_W-1:0]    r_index;
    logic [SUM_W-1:0]    r_acc;
    logic                r_sum_v;
    logic [SUM_W-1:0]    r_sum;
    logic [IDX_W-1:0]    n_index;
    logic [SUM_W-1:0]    n_acc;

    logic [CMP_W-1:0]    n_raw;
    logic [IDX_W-1:0]    n_eff;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    last;
    logic                is_final;
    logic [WEIGHT_W-1:0] weight;
    logic [SUM_W-1:0]    s_ext;
    logic [SUM_W-1:0]    term;
    logic                sum_rdy;
    logic                accept;

    assign n_raw = CMP_W'(i_cfg.num_intervals);

    always_comb begin
        if (n_raw == '0) begin
            n_eff = IDX_W'(1);
        end else if (n_raw > CMP_W'(MAX_INTERVALS)) begin
            n_eff = IDX_W'(MAX_INTERVALS);
        end else begin
            n_eff = IDX_W'(n_raw);
        end
    end

    assign idx      = (r_index > n_eff) ? n_eff : r_index;
    assign is_final = (idx == n_eff);
    assign last     = {n_eff[IDX_W-1:2], 2'b00};

    always_comb begin
        case (i_cfg.rule)
            RULE_SIMPSON: begin
                if (idx == '0 || is_final) begin
                    weight = W_ONE;
                end else begin
                    weight = idx[0] ? W_FOUR : W_TWO;
                end
            end
            RULE_BOOLE: begin
                if (last == '0 || idx > last) begin
                    weight = W_ZERO;
                end else if (idx == '0 || idx == last) begin
                    weight = W_SEVEN;
                end else if (idx[0]) begin
                    weight = W_THIRTYTWO;
                end else if (idx[1]) begin
                    weight = W_TWELVE;
                end else begin
                    weight = W_FOURTEEN;
                end
            end
            default: begin
                weight = (idx == '0 || is_final) ? W_ONE : W_TWO;
            end
        endcase
    end

    assign s_ext = SUM_W'(i_sample);
    assign term  = s_ext * SUM_W'(weight);
    assign n_acc = r_acc + term;

    assign sum_rdy = !r_sum_v || i_sum_ready;
    assign o_ready = !is_final || sum_rdy;
    assign accept  = i_valid && o_ready;

    assign n_index = idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_acc   <= '0;
            r_sum_v <= 1'b0;
        end else begin
            if (accept) begin
                if (is_final) begin
                    r_index <= '0;
                    r_acc   <= '0;
                end else begin
                    r_index <= n_index;
                    r_acc   <= n_acc;
                end
            end
            if (sum_rdy) begin
                r_sum_v <= accept && is_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_rdy && accept && is_final) begin
            r_sum <= n_acc;
        end
    end

    assign o_sum_valid = r_sum_v;
    assign o_sum       = r_sum;

    `NCSI_ASSERT_NXT(a_index_advance, accept && !is_final, r_index == $past(n_index))
    `NCSI_ASSERT_IMP(a_stall_only_on_final, !o_ready, r_sum_v && is_final)

endmodule

// ----- rtl/core/ncsi_scale.sv -----
// Scaling pipeline: magnitude, split product, rounding, saturation, result register.
// Depends on ncsi_pkg and the assertion macro header.
`include "newton_cotes_sample_integrator_unit_macros.svh"
module ncsi_scale
    import ncsi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [SCALE_W-1:0]         i_step_scale,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SUM_W-1:0]           i_sum,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [RESULT_W-1:0] o_integral,
    output logic                       o_saturated
);

    logic                 r_v2, r_v3, r_v4, r_v5, r_v6;
    logic                 rdy2, rdy3, rdy4, rdy5, rdy6;

    logic                 r_neg2, r_neg3, r_neg4, r_neg5;
    logic [SUM_W-1:0]     r_mag2;
    logic [PROD_LO_W-1:0] r_plo3;
    logic [PROD_HI_W-1:0] r_phi3;
    logic [MID_W-1:0]     r_mid4;
    logic [RND_W-1:0]     r_rnd4;
    logic [RESULT_W-1:0]  r_r5;
    logic                 r_big5;
    logic [RESULT_W-1:0]  r_integral;
    logic                 r_sat;

    logic [SUM_W-1:0]     n_mag2;
    logic [PROD_LO_W-1:0] n_plo3;
    logic [PROD_HI_W-1:0] n_phi3;
    logic [MID_W-1:0]     n_mid4;
    logic [LO_W:0]        rnd_sum;
    logic [RND_W-1:0]     n_rnd4;
    logic [RESULT_W-1:0]  n_r5;
    logic                 n_big5;
    logic [RESULT_W-1:0]  lim;
    logic                 n_sat;
    logic [RESULT_W-1:0]  clamped;
    logic [RESULT_W-1:0]  n_integral;

    assign rdy6 = !r_v6 || i_ready;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;

    assign n_mag2 = i_sum[SUM_W-1] ? (SUM_W'(0) - i_sum) : i_sum;

    assign n_plo3 = PROD_LO_W'(r_mag2[LO_W-1:0]) * PROD_LO_W'(i_step_scale);
    assign n_phi3 = PROD_HI_W'(r_mag2[SUM_W-1:LO_W]) * PROD_HI_W'(i_step_scale);

    assign n_mid4  = MID_W'(r_plo3[PROD_LO_W-1:LO_W]) + MID_W'(r_phi3);
    assign rnd_sum = {1'b0, r_plo3[LO_W-1:0]} + RND_HALF;
    assign n_rnd4  = rnd_sum[LO_W:LO_W-RND_W+1];

    assign n_big5 = |r_mid4[MID_W-1:RESULT_W-17];
    assign n_r5   = {1'b0, r_mid4[RESULT_W-18:0], 16'h0000} + RESULT_W'(r_rnd4);

    assign lim        = r_neg5 ? RESULT_MIN : RESULT_MAX;
    assign n_sat      = r_big5 || (r_r5 > lim);
    assign clamped    = n_sat ? lim : r_r5;
    assign n_integral = r_neg5 ? (RESULT_W'(0) - clamped) : clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (rdy2) r_v2 <= i_valid;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_mag2 <= n_mag2;
            r_neg2 <= i_sum[SUM_W-1];
        end
        if (rdy3) begin
            r_plo3 <= n_plo3;
            r_phi3 <= n_phi3;
            r_neg3 <= r_neg2;
        end
        if (rdy4) begin
            r_mid4 <= n_mid4;
            r_rnd4 <= n_rnd4;
            r_neg4 <= r_neg3;
        end
        if (rdy5) begin
            r_r5   <= n_r5;
            r_big5 <= n_big5;
            r_neg5 <= r_neg4;
        end
        if (rdy6) begin
            r_integral <= n_integral;
            r_sat      <= n_sat;
        end
    end

    assign o_ready     = rdy2;
    assign o_valid     = r_v6;
    assign o_integral  = r_integral;
    assign o_saturated = r_sat;

    `NCSI_ASSERT_IMP(a_sat_at_limit, r_v6 && r_sat, r_integral == RESULT_MAX || r_integral == RESULT_MIN)
    `NCSI_ASSERT_IMP(a_full_when_blocked, !rdy2, r_v2 && r_v3 && r_v4 && r_v5 && r_v6)

endmodule

// ----- rtl/core/newton_cotes_sample_integrator_unit.sv -----
// Composite Newton-Cotes integrator (trapezoid, Simpson, Boole) over streamed samples.
// Samples enter on i_valid/o_ready; one result per run leaves on o_valid/i_ready.
// Configuration arrives on i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data:
// index 0 rule, 1 interval count, 2 step scale (unsigned Q16.16). Write only when idle.
// A run is interval count plus one samples; the last one closes the run and clears the sum.
// Throughput: one sample per cycle while o_ready is high; the weighted sum updates in the cycle of the transfer.
// The sum register loads at the transfer of the final sample, then five scaling stages
// follow (magnitude, partial products, merge and round, assemble, saturate).
// A stalled receiver holds the result register; the pipeline keeps filling behind it and
// o_ready drops only when a final sample meets a full pipeline.
// Reset clears the sample index, the running sum, all pipeline valids and restores the
// registers to trapezoid, four intervals and a unit step scale.
// Depends on ncsi_pkg, ncsi_cfg, ncsi_accum and ncsi_scale.
module newton_cotes_sample_integrator_unit
    import ncsi_pkg::*;
#(
    parameter int MAX_INTERVALS = 4096,
    parameter int SAMPLE_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [RESULT_W-1:0]     o_integral,
    output logic                           o_saturated
);

    t_cfg             cfg;
    logic             sum_valid;
    logic             sum_ready;
    logic [SUM_W-1:0] sum;

    ncsi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ncsi_accum #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_sum_valid (sum_valid),
        .i_sum_ready (sum_ready),
        .o_sum       (sum)
    );

    ncsi_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_scale (cfg.step_scale),
        .i_valid      (sum_valid),
        .o_ready      (sum_ready),
        .i_sum        (sum),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_integral   (o_integral),
        .o_saturated  (o_saturated)
    );

endmodule

// ----- sim/tb_newton_cotes_sample_integrator_unit.sv -----
// Self-checking testbench for newton_cotes_sample_integrator_unit: streams sample runs under
// every rule and a range of interval counts and step scales, and checks each integral against a built-in model.
// Depends on ncsi_pkg and the integrator RTL.
module tb_newton_cotes_sample_integrator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ncsi_pkg::*;

    localparam int INTERVAL_CAP  = 4096;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1750;

    localparam logic [1:0]             RULE_SPARE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE  = 2'd3;

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic                clipped;
    } t_integral;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   sample_valid = 1'b0;
    logic [31:0]            sample_data  = '0;
    logic                   result_ready = 1'b0;
    wire                    cfg_ready;
    wire                    sample_ready;
    wire                    result_valid;
    wire [RESULT_W-1:0]     result_integral;
    wire                    result_saturated;

    // Model state and register copies
    logic [1:0]         model_rule;
    logic [NI_W-1:0]    model_intervals;
    logic [SCALE_W-1:0] model_scale;
    logic [NI_W-1:0]    run_index;
    logic [SUM_W-1:0]   run_sum;

    t_integral pending_integrals[$];

    int error_count    = 0;
    int cycle_count    = 0;
    int sample_count   = 0;
    int integral_count = 0;
    int clipped_count  = 0;
    int write_count    = 0;
    bit steady         = 1'b0;

    newton_cotes_sample_integrator_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (sample_valid),
        .o_ready     (sample_ready),
        .i_sample    (sample_data),
        .o_valid     (result_valid),
        .i_ready     (result_ready),
        .o_integral  (result_integral),
        .o_saturated (result_saturated)
    );

    always #2 clk = ~clk;

    function automatic logic [NI_W-1:0] effective_intervals();
        if (model_intervals == '0) return 13'd1;
        if (model_intervals > INTERVAL_CAP) return 13'(INTERVAL_CAP);
        return model_intervals;
    endfunction

    function automatic logic [WEIGHT_W-1:0] grid_weight(input logic [NI_W-1:0] idx,
                                                       input logic [NI_W-1:0] n);
        logic [NI_W-1:0] panel_end;
        panel_end = n & ~13'd3;
        case (model_rule)
            RULE_SIMPSON: begin
                if (idx == 0 || idx == n) return W_ONE;
                return idx[0] ? W_FOUR : W_TWO;
            end
            RULE_BOOLE: begin
                if (panel_end == 0 || idx > panel_end) return W_ZERO;
                if (idx == 0 || idx == panel_end) return W_SEVEN;
                if (idx[0]) return W_THIRTYTWO;
                return (idx[1:0] == 2'd2) ? W_TWELVE : W_FOURTEEN;
            end
            default: begin
                if (idx == 0 || idx == n) return W_ONE;
                return W_TWO;
            end
        endcase
    endfunction

    function automatic t_integral scale_weighted_sum(input logic [SUM_W-1:0] sum,
                                                     input logic [SCALE_W-1:0] scale);
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [83:0]      prod;
        logic [83:0]      rounded;
        logic [67:0]      bound;
        t_integral        res;
        neg     = sum[SUM_W-1];
        mag     = neg ? -sum : sum;
        prod    = {32'b0, mag} * {52'b0, scale};
        bound   = neg ? (68'd1 << 63) : ((68'd1 << 63) - 68'd1);
        rounded = (prod + 84'h8000) >> 16;
        res.clipped = 1'b0;
        if (|prod[83:79] || rounded[67:0] > bound) begin
            rounded     = {16'b0, bound};
            res.clipped = 1'b1;
        end
        res.value = neg ? -rounded[63:0] : rounded[63:0];
        return res;
    endfunction

    task automatic accumulate_sample(input logic [31:0] s);
        logic [NI_W-1:0]  n;
        logic [NI_W-1:0]  idx;
        logic [SUM_W-1:0] ext;
        n   = effective_intervals();
        idx = (run_index > n) ? n : run_index;
        ext = {{(SUM_W-32){s[31]}}, s};
        run_sum = run_sum + ext * {46'b0, grid_weight(idx, n)};
        if (idx < n) begin
            run_index = idx + 13'd1;
        end else begin
            pending_integrals.push_back(scale_weighted_sum(run_sum, model_scale));
            run_index = '0;
            run_sum   = '0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic send_sample(input logic [31:0] s);
        while (!steady && $urandom_range(99) < 7) begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        do @(posedge clk); while (!sample_ready);
        accumulate_sample(s);
        sample_count++;
    endtask

    // Hold the sample channel until every integral is out and the pipeline is empty.
    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_integrals.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RULE:          model_rule      = value[1:0];
            CFG_NUM_INTERVALS: model_intervals = value[NI_W-1:0];
            CFG_STEP_SCALE:    model_scale     = value;
            default: ;
        endcase
        write_count++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input logic [1:0] r, input logic [31:0] n,
                                input logic [31:0] scale);
        write_reg(CFG_RULE, {30'b0, r});
        write_reg(CFG_NUM_INTERVALS, n);
        write_reg(CFG_STEP_SCALE, scale);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        settle();
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0001_0000);
    endtask

    task automatic test_each_rule();
        int k;
        settle();
        write_config(RULE_SIMPSON, 2, 32'h0000_5555);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        settle();
        // Boole with a tail past the last full panel
        write_config(RULE_BOOLE, 6, 32'hFFFF_FFFF);
        for (k = 0; k < 7; k++) send_sample(32'h0123_4567 * (k + 1));
        settle();
        write_config(RULE_BOOLE, 3, 32'h0001_0000);
        for (k = 0; k < 4; k++) send_sample(32'h7FFF_FFFF);
        settle();
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        write_config(RULE_SPARE, 0, 32'h0001_8000);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0001);
    endtask

    task automatic test_midrun_interval_change();
        int k;
        settle();
        write_config(RULE_TRAP, 8, 32'h0001_0000);
        for (k = 0; k < 4; k++) send_sample(pick_sample());
        settle();
        // index is now past the new count: the next sample closes the run
        write_reg(CFG_NUM_INTERVALS, 2);
        send_sample(32'h0002_0000);
    endtask

    task automatic test_saturation();
        int k;
        settle();
        steady = 1'b1;
        write_config(RULE_BOOLE, 32'h0000_1FFF, 32'hFFFF_FFFF);
        for (k = 0; k <= INTERVAL_CAP; k++) send_sample(32'h7FFF_FFFF);
        steady = 1'b0;
        settle();
        write_reg(CFG_NUM_INTERVALS, INTERVAL_CAP);
        for (k = 0; k <= INTERVAL_CAP; k++)
            send_sample(($urandom_range(9) == 0) ? $urandom : 32'h8000_0000);
    endtask

    task automatic test_random_runs();
        int          phase;
        int          runs;
        int          r;
        int          k;
        int          len;
        int          start;
        logic [31:0] n;
        logic [31:0] scale;
        phase = 0;
        start = sample_count;
        while (sample_count - start < RANDOM_ITEMS) begin
            settle();
            steady = (phase >= 6 && phase < 14);
            case ($urandom_range(19))
                0:       n = 0;
                1:       n = $urandom_range(100, 400);
                2, 3, 4: n = $urandom_range(13, 64);
                default: n = $urandom_range(1, 12);
            endcase
            case ($urandom_range(9))
                0:       scale = 32'h0000_0000;
                1:       scale = 32'hFFFF_FFFF;
                2:       scale = 32'h0001_0000;
                default: scale = $urandom;
            endcase
            write_config(2'($urandom_range(3)), n, scale);
            runs = $urandom_range(1, 6);
            for (r = 0; r < runs; r++) begin
                len = effective_intervals() + 1;
                for (k = 0; k < len; k++) begin
                    send_sample(pick_sample());
                    if ($urandom_range(199) == 0) settle();
                end
            end
            // leave a run open so the next settings land mid-run
            if ($urandom_range(4) == 0) begin
                len = $urandom_range(0, effective_intervals() - 1);
                for (k = 0; k < len; k++) send_sample(pick_sample());
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    always @(posedge clk) begin
        t_integral want;
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else begin
            result_ready <= steady || ($urandom_range(99) >= 7);
        end
        if (rst_n && result_valid && result_ready) begin
            if (pending_integrals.size() == 0) begin
                report_mismatch($sformatf("integral %h with none expected", result_integral));
            end else begin
                want = pending_integrals.pop_front();
                integral_count++;
                if (want.clipped) clipped_count++;
                if (result_integral !== want.value)
                    report_mismatch($sformatf("integral %h, expected %h",
                                              result_integral, want.value));
                if (result_saturated !== want.clipped)
                    report_mismatch($sformatf("saturated %b, expected %b",
                                              result_saturated, want.clipped));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d integrals outstanding",
                     cycle_count, pending_integrals.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        model_rule      = RULE_TRAP;
        model_intervals = NUM_INTERVALS_RESET;
        model_scale     = STEP_SCALE_RESET;
        run_index       = '0;
        run_sum         = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_each_rule();
        test_midrun_interval_change();
        test_saturation();
        test_random_runs();
        settle();
        $display("Streamed %0d samples over all rules; %0d integrals checked, %0d clipped.",
                 sample_count, integral_count, clipped_count);
        $display("Register transfers: %0d, mismatches: %0d.", write_count, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ncsi_pkg.sv
rtl/core/ncsi_cfg.sv
rtl/core/ncsi_accum.sv
rtl/core/ncsi_scale.sv
rtl/core/newton_cotes_sample_integrator_unit.sv
sim/tb_newton_cotes_sample_integrator_unit.sv
